@@ src/zsss_pkg.sv @@
// ----------------------------------------------------------------------------
// zsss_pkg
// shared command codes and controller/datapath interface types for the
// zero-sum subset search block
// ----------------------------------------------------------------------------
package zsss_pkg;

    localparam int CMD_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic advance;
        logic capture;
    } zsss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic exhausted;
    } zsss_stat_t;

endpackage

@@ src/zero_sum_subset_search_top.sv @@
// ----------------------------------------------------------------------------
// zero_sum_subset_search_top
// loads signed elements and returns, one per find command, the next subset
// mask in ascending order whose members sum to zero
//
// channel  dir  tdata                          tuser
// s_*      in   value [VALUE_BITS-1:0]          command [1:0]
// m_*      out  subset_mask [MAX_ELEMENTS-1:0]  found
//
// a find steps the running-sum adder through the masks in order, one mask
// per cycle, until a mask sums to zero or the scan of the loaded elements
// runs out
// one command is in work at a time; clear and append are accepted while a
// result waits on the master side, a find stalls at its result until then
// reset empties the set and restarts the scan at mask 1
// ----------------------------------------------------------------------------
module zero_sum_subset_search_top #(
    parameter int MAX_ELEMENTS = 10,
    parameter int VALUE_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0]  s_tdata,   // value
    input  logic [zsss_pkg::CMD_BITS-1:0]          s_tuser,   // command
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((MAX_ELEMENTS + 7) / 8) * 8-1:0] m_tdata,  // subset_mask
    output logic                                  m_tuser    // found
);
    import zsss_pkg::*;

    localparam int OUT_BITS = ((MAX_ELEMENTS + 7) / 8) * 8;

    zsss_cmd_t               cmd;
    zsss_stat_t              stat;
    logic [MAX_ELEMENTS-1:0] out_mask;
    logic                    out_found;

    zsss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    zsss_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     ($signed(s_tdata[VALUE_BITS-1:0])),
        .stat      (stat),
        .out_mask  (out_mask),
        .out_found (out_found)
    );

    assign m_tdata = OUT_BITS'(out_mask);
    assign m_tuser = out_found;

endmodule

@@ src/zsss_dp.sv @@
// ----------------------------------------------------------------------------
// zsss_dp
// element deltas, scan mask, running subset sum and result register; the
// sum of the next mask is formed from the current one with a single add
// ----------------------------------------------------------------------------
module zsss_dp #(
    parameter int MAX_ELEMENTS = 10,
    parameter int VALUE_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  zsss_pkg::zsss_cmd_t          cmd,
    input  logic signed [VALUE_BITS-1:0] value,
    output zsss_pkg::zsss_stat_t         stat,
    output logic [MAX_ELEMENTS-1:0]      out_mask,
    output logic                         out_found
);
    import zsss_pkg::*;

    localparam int CW       = $clog2(MAX_ELEMENTS + 1);
    localparam int IW       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SUM_BITS = VALUE_BITS + $clog2(MAX_ELEMENTS) + 2;

    logic [CW-1:0]              count_reg, count_next;
    logic [MAX_ELEMENTS:0]      mask_reg, mask_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic signed [SUM_BITS-1:0] total_reg, total_next;
    logic signed [SUM_BITS-1:0] delta_mem [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]    out_mask_reg;
    logic                       out_found_reg;

    logic signed [SUM_BITS-1:0] value_ext;
    logic signed [SUM_BITS-1:0] delta_rd;
    logic [CW-1:0]              trail;
    logic                       wrap;
    logic                       full;
    logic                       exhausted;
    logic                       hit;

    assign value_ext = {{(SUM_BITS - VALUE_BITS){value[VALUE_BITS-1]}}, value};
    assign full      = (count_reg == CW'(MAX_ELEMENTS));
    assign exhausted = mask_reg[count_reg];
    assign hit       = (sum_reg == '0) && !exhausted;

    // number of trailing ones of the current mask
    always_comb
    begin
        trail = CW'(MAX_ELEMENTS);
        for (int k = MAX_ELEMENTS; k >= 0; k--)
        begin
            if (!mask_reg[k])
            begin
                trail = CW'(k);
            end
        end
    end

    assign wrap     = (trail == count_reg);
    assign delta_rd = delta_mem[trail[IW-1:0]];

    always_comb
    begin
        count_next = count_reg;
        mask_next  = mask_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            mask_next  = (MAX_ELEMENTS + 1)'(1);
            sum_next   = '0;
            total_next = '0;
        end
        else if (cmd.append && !full)
        begin
            count_next = count_reg + 1'b1;
            total_next = total_reg + value_ext;
            if (mask_reg[count_reg])
            begin
                sum_next = sum_reg + value_ext;
            end
        end
        else if (cmd.advance)
        begin
            mask_next = mask_reg + 1'b1;
            sum_next  = wrap ? '0 : (sum_reg + delta_rd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mask_reg  <= (MAX_ELEMENTS + 1)'(1);
            sum_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            mask_reg  <= mask_next;
            sum_reg   <= sum_next;
            total_reg <= total_next;
        end
    end

    // delta of element c is its value minus the sum of elements below it
    always_ff @(posedge clk)
    begin
        if (cmd.append && !cmd.clear && !full)
        begin
            delta_mem[count_reg[IW-1:0]] <= value_ext - total_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_found_reg <= hit;
            out_mask_reg  <= hit ? mask_reg[MAX_ELEMENTS-1:0] : '0;
        end
    end

    assign stat.hit       = hit;
    assign stat.exhausted = exhausted;
    assign out_mask       = out_mask_reg;
    assign out_found      = out_found_reg;

    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg != '0)
        else $error("scan mask is zero");

    a_mask_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg >> count_reg) <= (MAX_ELEMENTS + 1)'(1))
        else $error("scan mask beyond loaded range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("element count overflow");

    a_no_advance_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !exhausted)
        else $error("advance past end of scan");

endmodule

@@ src/zsss_ctrl.sv @@
// ----------------------------------------------------------------------------
// zsss_ctrl
// command decode and scan sequencer; owns the result valid flag and stalls
// the scan while a finished result has not been taken
// ----------------------------------------------------------------------------
module zsss_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [zsss_pkg::CMD_BITS-1:0]   command,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output zsss_pkg::zsss_cmd_t             cmd,
    input  zsss_pkg::zsss_stat_t            stat
);
    import zsss_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   accept;
    logic   out_free;
    logic   done;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;
    assign done     = stat.hit || stat.exhausted;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_CLEAR:  cmd.clear  = 1'b1;
                        CMD_APPEND: cmd.append = 1'b1;
                        CMD_FIND:   state_next = ST_SCAN;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    if (out_free)
                    begin
                        cmd.capture = 1'b1;
                        cmd.advance = stat.hit;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        valid_next = cmd.capture ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> out_free)
        else $error("result overwritten before transaction");

    a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> m_tvalid)
        else $error("captured result not presented");

    a_scan_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !(cmd.clear || cmd.append))
        else $error("store changed during scan");

endmodule
